// File: src/assert_macros.svh
// Assertion macros shared by the scratchpad CRC checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, during reset too.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/owcrc_pkg.sv
// Types, constants and the CRC-8 step function of the scratchpad CRC checker.
`timescale 1ns / 1ps

package owcrc_pkg;

    // Byte counter width and frame length in bytes.
    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] SCRATCHPAD_BYTES = 4'd9;

    // Reflected Dallas/Maxim CRC-8 polynomial.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Sentinel temperature given on CRC failure: -32000 sixteenths.
    localparam logic signed [15:0] ERROR_TEMP = 16'sh8300;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] scratch_byte;
        logic       frame_start;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [15:0] temp_sixteenths;
        logic               crc_error;
    } out_t;

    // Frame tracker output for one byte: whether the frame ended, and its result.
    typedef struct packed {
        logic done;
        out_t res;
    } frame_res_t;

    // One byte of the CRC, shifted in least significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ d[0];
            c  = {1'b0, c[7:1]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// File: src/onewire_scratchpad_crc_check.sv
// Top level of the 1-Wire scratchpad CRC checker with input and result registers.
//
//   channel   direction   handshake              payload
//   in        to block    in_valid / in_ready    in_data  (scratch_byte, frame_start)
//   out       from block  out_valid / out_ready  out_data (temp_sixteenths, crc_error)
//
// One byte transaction is taken per cycle while in_ready is high; the CRC of a byte is
// eight unrolled XOR shifts. A byte waits in the input register until the result
// register can take a value; its frame result is then loaded into the result register.
// Reset clears the frame count, CRC and both valid flags; no clearing pass is needed.
// A stalled result register holds the input register, and in_ready drops only while both
// are full and out_ready is low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module onewire_scratchpad_crc_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  owcrc_pkg::in_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output owcrc_pkg::out_t   out_data
);
    import owcrc_pkg::*;

    logic       stage_valid_reg;
    in_t        stage_data_reg;
    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg;
    logic       advance;
    frame_res_t frame_res;

    // The input register moves on whenever the result register can take a value.
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    owcrc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_data_reg),
        .result (frame_res)
    );

    // Result register fills at a frame end and empties when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && frame_res.done)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_data_reg <= in_data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_res.done)
        begin
            out_data_reg <= frame_res.res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_CLK(a_stage_holds, stage_valid_reg && !advance |=> stage_valid_reg,
                "pending byte lost while result register stalled")
    `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_reg && !stage_valid_reg,
                       "valid flags set during reset")

endmodule

// File: src/owcrc_frame.sv
// Frame tracker: running CRC, byte count and temperature bytes of one scratchpad frame.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module owcrc_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  owcrc_pkg::in_t          item,
    output owcrc_pkg::frame_res_t   result
);
    import owcrc_pkg::*;

    logic [7:0]         crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         temp_low_reg, temp_low_next;
    logic [7:0]         temp_high_reg, temp_high_next;

    logic [7:0]         crc_base;
    logic [COUNT_W-1:0] count_base;
    logic [7:0]         crc_upd;
    logic [COUNT_W-1:0] count_inc;
    logic               done;

    // A frame start restarts the count and CRC before the byte is taken.
    always_comb
    begin
        crc_base   = item.frame_start ? 8'h00 : crc_reg;
        count_base = item.frame_start ? '0 : count_reg;
        crc_upd    = crc8_update(crc_base, item.scratch_byte);
        count_inc  = count_base + {{(COUNT_W-1){1'b0}}, 1'b1};
        done       = (count_inc >= SCRATCHPAD_BYTES) || (count_inc == '0);
    end

    // The first two bytes of a frame are the low and high temperature halves.
    always_comb
    begin
        temp_low_next  = (count_base == '0) ? item.scratch_byte : temp_low_reg;
        temp_high_next = (count_base == {{(COUNT_W-1){1'b0}}, 1'b1}) ?
                         item.scratch_byte : temp_high_reg;
        crc_next       = done ? 8'h00 : crc_upd;
        count_next     = done ? '0 : count_inc;
    end

    // Result of the byte, meaningful when done is set.
    always_comb
    begin
        result.done = done;
        if (crc_upd == 8'h00)
        begin
            result.res.temp_sixteenths = signed'({temp_high_next, temp_low_next});
            result.res.crc_error       = 1'b0;
        end
        else
        begin
            result.res.temp_sixteenths = ERROR_TEMP;
            result.res.crc_error       = 1'b1;
        end
    end

    // Frame state advances once per byte transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 8'h00;
            count_reg     <= '0;
            temp_low_reg  <= 8'h00;
            temp_high_reg <= 8'h00;
        end
        else if (step)
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            temp_low_reg  <= temp_low_next;
            temp_high_reg <= temp_high_next;
        end
    end

    `ASSERT_CLK(a_count_in_frame, count_reg < SCRATCHPAD_BYTES, "byte count ran past frame")
    `ASSERT_CLK(a_end_clears, step && done |=> count_reg == '0 && crc_reg == 8'h00,
                "finished frame did not clear count and CRC")
    `ASSERT_CLK(a_error_sentinel,
                result.res.crc_error |-> result.res.temp_sixteenths == ERROR_TEMP,
                "CRC error without sentinel temperature")

endmodule

// File: bench/onewire_scratchpad_crc_check_tb.sv
// Self-checking testbench for the 1-Wire scratchpad CRC checker.
`timescale 1ns / 1ps

module onewire_scratchpad_crc_check_tb;

    import owcrc_pkg::*;

    // Cycles with no accepted transaction on either channel before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;
    // Cycles spent watching for stray results once every owed result has arrived.
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1700;

    // Tracks the frame state of the block and holds the temperatures still owed by it.
    class frame_temp_tracker;
        logic [7:0]         crc_run;
        logic [COUNT_W-1:0] bytes_seen;
        logic [7:0]         low_byte;
        logic [7:0]         high_byte;
        out_t               temps_due[$];
        int                 errors;

        function new();
            crc_run    = '0;
            bytes_seen = '0;
            low_byte   = '0;
            high_byte  = '0;
            errors     = 0;
        endfunction

        // Reflected CRC-8, polynomial 0x8C: fold the byte in, then eight shifts.
        static function logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function int pending();
            return temps_due.size();
        endfunction

        // Advance the frame state by one accepted byte and queue the result it causes.
        function void note_byte(input in_t item);
            out_t res;
            if (item.frame_start)
            begin
                bytes_seen = '0;
                crc_run    = '0;
            end
            crc_run = crc8_byte(crc_run, item.scratch_byte);
            if (bytes_seen == 0)
            begin
                low_byte = item.scratch_byte;
            end
            else if (bytes_seen == 1)
            begin
                high_byte = item.scratch_byte;
            end
            bytes_seen = bytes_seen + 1'b1;

            // The count wraps at zero as well as stopping at the frame length.
            if (bytes_seen >= SCRATCHPAD_BYTES || bytes_seen == 0)
            begin
                if (crc_run == 8'h00)
                begin
                    res.temp_sixteenths = {high_byte, low_byte};
                    res.crc_error       = 1'b0;
                end
                else
                begin
                    res.temp_sixteenths = ERROR_TEMP;
                    res.crc_error       = 1'b1;
                end
                temps_due.push_back(res);
                bytes_seen = '0;
                crc_run    = '0;
            end
        endfunction

        // Compare one accepted result with the oldest owed temperature.
        function void check_temp(input out_t got);
            out_t want;
            if (temps_due.size() == 0)
            begin
                $error("unexpected result: temp_sixteenths %0d crc_error %0b",
                       got.temp_sixteenths, got.crc_error);
                errors++;
                return;
            end
            want = temps_due.pop_front();
            if (got.temp_sixteenths !== want.temp_sixteenths)
            begin
                $error("temp_sixteenths: expected %0d, actual %0d",
                       want.temp_sixteenths, got.temp_sixteenths);
                errors++;
            end
            if (got.crc_error !== want.crc_error)
            begin
                $error("crc_error: expected %0b, actual %0b", want.crc_error, got.crc_error);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    frame_temp_tracker frames = new();

    int burst_left;
    int items_sent;
    bit calm;
    int idle_cycles;

    onewire_scratchpad_crc_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: alternate stalls and ready runs of random length; always ready when calm.
    int  sink_hold;
    bit  sink_level;

    always @(posedge clk)
    begin
        if (sink_hold == 0)
        begin
            if (calm)
            begin
                sink_level = 1'b1;
                sink_hold  = 16;
            end
            else
            begin
                sink_level = ~sink_level;
                sink_hold  = sink_level ? $urandom_range(1, 10) : $urandom_range(1, 12);
            end
        end
        else
        begin
            sink_hold--;
        end
        out_ready <= sink_level;
    end

    // Observe both channels and run the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frames.note_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                frames.check_temp(out_data);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** onewire_scratchpad_crc_check: FAILED **");
                $finish;
            end
        end
    end

    // Offer one byte and wait until it is taken; bursts are separated by random gaps.
    task automatic push_byte(input in_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_sent++;
    endtask

    // Stop sending until every owed result has been taken.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One full frame carrying the given temperature; the last byte is the CRC of the rest.
    // A corrupted frame has one bit flipped, which the CRC always catches.
    task automatic send_frame(input logic [15:0] temp, input bit mark_start, input bit corrupt);
        logic [7:0] bytes [16];
        logic [7:0] crc;
        int         n;
        int         pos;
        int         bitpos;
        in_t        item;
        n = int'(SCRATCHPAD_BYTES);
        bytes[0] = temp[7:0];
        bytes[1] = temp[15:8];
        for (int i = 2; i < n - 1; i++)
        begin
            bytes[i] = 8'($urandom);
        end
        crc = 8'h00;
        for (int i = 0; i < n - 1; i++)
        begin
            crc = frame_temp_tracker::crc8_byte(crc, bytes[i]);
        end
        bytes[n-1] = crc;
        if (corrupt)
        begin
            pos    = $urandom_range(0, n - 1);
            bitpos = $urandom_range(0, 7);
            bytes[pos] = bytes[pos] ^ (8'h01 << bitpos);
        end
        for (int i = 0; i < n; i++)
        begin
            item.scratch_byte = bytes[i];
            item.frame_start  = (i == 0) && mark_start;
            push_byte(item);
        end
    endtask

    // A run of random bytes, the first one marked as a frame start when asked, later ones at random when asked.
    task automatic send_loose_bytes(input int count, input bit first_start, input bit rand_start);
        in_t item;
        for (int i = 0; i < count; i++)
        begin
            item.scratch_byte = 8'($urandom);
            item.frame_start  = (i == 0) ? first_start : (rand_start && $urandom_range(0, 3) == 0);
            push_byte(item);
        end
    endtask

    // Mostly random temperatures, with the extremes and the sentinel value now and then.
    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4:       return ERROR_TEMP;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus.
    initial
    begin
        int  pick;
        int  next_switch;
        bit  drained;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        burst_left  = 0;
        items_sent  = 0;
        calm        = 1'b0;
        drained     = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any frame start form a frame counted from reset.
        send_frame(16'h8000, 1'b0, 1'b0);
        // A frame start in the middle of a frame drops the partial frame.
        send_loose_bytes(2, 1'b1, 1'b0);
        send_frame(16'h7FFF, 1'b1, 1'b0);
        // After a finished frame the next byte opens a frame without a start mark.
        send_frame(16'hFFFF, 1'b0, 1'b0);
        // A bad CRC gives the sentinel and the error flag.
        send_frame(16'h0000, 1'b1, 1'b1);

        wait_all_results();

        // Random part: mostly well-formed frames, some corrupted, some broken or noisy.
        items_sent  = 0;
        next_switch = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= next_switch)
            begin
                calm        = ($urandom_range(0, 2) == 0);
                next_switch = next_switch + 200;
            end
            if (!drained && items_sent >= RANDOM_ITEMS / 2)
            begin
                wait_all_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_frame(pick_temp(), $urandom_range(0, 3) != 0, 1'b0);
            end
            else if (pick < 85)
            begin
                send_frame(pick_temp(), $urandom_range(0, 3) != 0, 1'b1);
            end
            else if (pick < 93)
            begin
                send_loose_bytes($urandom_range(1, SCRATCHPAD_BYTES - 1), 1'b1, 1'b0);
            end
            else
            begin
                send_loose_bytes($urandom_range(1, 5), 1'($urandom_range(0, 1)), 1'b1);
            end
        end

        // Let every owed result arrive, then watch for strays.
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frames.errors == 0)
        begin
            $display("** onewire_scratchpad_crc_check: PASSED **");
        end
        else
        begin
            $display("** onewire_scratchpad_crc_check: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/owcrc_pkg.sv
src/owcrc_frame.sv
src/onewire_scratchpad_crc_check.sv
bench/onewire_scratchpad_crc_check_tb.sv
